>>> design/ctse_pkg.sv
// ----------------------------------------------------------------------------
// ctse_pkg
// Shared types, codes and digit arithmetic for the 24-hour time set editor.
// ----------------------------------------------------------------------------
package ctse_pkg;

   // Event codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_PRESS = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_EDITING = 3'd0;
   localparam logic [2:0] ST_COMMIT  = 3'd1;
   localparam logic [2:0] ST_CANCEL  = 3'd2;
   localparam logic [2:0] ST_TIMEOUT = 3'd3;
   localparam logic [2:0] ST_IGNORED = 3'd4;

   // Digit positions
   localparam logic [2:0] DIG_HOUR_TENS = 3'd1;
   localparam logic [2:0] DIG_HOUR_UNIT = 3'd2;
   localparam logic [2:0] DIG_MIN_TENS  = 3'd3;
   localparam logic [2:0] DIG_MIN_UNIT  = 3'd4;
   localparam logic [2:0] DIG_DONE      = 3'd5;

   // Limits
   localparam logic [4:0]  HOURS_MAX    = 5'd23;
   localparam logic [5:0]  MINUTES_MAX  = 6'd59;
   localparam logic [15:0] IDLE_TICKS_RESET = 16'd1000;

   // Configuration register map
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam logic        CSR_IDX_IDLE_TICKS = 1'b0;

   typedef struct packed {
      logic [1:0] opcode;
      logic       btn_next;
      logic       btn_cancel;
      logic       btn_up;
      logic       btn_down;
      logic [4:0] start_hours;
      logic [5:0] start_minutes;
   } req_data_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] edit_hours;
      logic [5:0] edit_minutes;
      logic [2:0] selected_digit;
   } rsp_data_type;

   typedef struct packed {
      logic        editing;
      logic [2:0]  digit_sel;
      logic [4:0]  hours_val;
      logic [5:0]  minutes_val;
      logic [15:0] idle_left;
   } state_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
   } hm_type;

   // Tens of a value below 64, by compare ladder
   function automatic logic [2:0] tens_of(input logic [5:0] v);
      logic [2:0] t;
      if (v >= 6'd60)      t = 3'd6;
      else if (v >= 6'd50) t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else if (v >= 6'd10) t = 3'd1;
      else                 t = 3'd0;
      return t;
   endfunction

   // Units left after taking the tens off
   function automatic logic [3:0] units_of(input logic [5:0] v, input logic [2:0] t);
      logic [6:0] r;
      r = 7'(v) - 7'(t) * 7'd10;
      return r[3:0];
   endfunction

   // Increment the selected digit with wrap
   function automatic hm_type digit_up(input logic [2:0] sel, input hm_type v);
      logic [2:0] ht, mt;
      logic [3:0] hu, mu;
      hm_type     r;
      ht = tens_of({1'b0, v.hours});
      hu = units_of({1'b0, v.hours}, ht);
      mt = tens_of(v.minutes);
      mu = units_of(v.minutes, mt);
      r  = v;
      case (sel)
         DIG_HOUR_TENS: r.hours = (ht < 3'd2) ? 5'(v.hours + 5'd10) : 5'(hu);
         DIG_HOUR_UNIT: begin
            if (ht < 3'd2)
               r.hours = (hu < 4'd9) ? 5'(v.hours + 5'd1) : 5'(5'(ht) * 5'd10);
            else
               r.hours = (hu < 4'd3) ? 5'(v.hours + 5'd1) : 5'(5'(ht) * 5'd10);
         end
         DIG_MIN_TENS:  r.minutes = (mt < 3'd5) ? 6'(v.minutes + 6'd10) : 6'(mu);
         DIG_MIN_UNIT:  r.minutes = (mu < 4'd9) ? 6'(v.minutes + 6'd1)
                                                : 6'(6'(mt) * 6'd10);
         default: ;
      endcase
      return r;
   endfunction

   // Decrement the selected digit with wrap
   function automatic hm_type digit_down(input logic [2:0] sel, input hm_type v);
      logic [2:0] ht, mt;
      logic [3:0] hu, mu;
      hm_type     r;
      ht = tens_of({1'b0, v.hours});
      hu = units_of({1'b0, v.hours}, ht);
      mt = tens_of(v.minutes);
      mu = units_of(v.minutes, mt);
      r  = v;
      case (sel)
         DIG_HOUR_TENS: r.hours = (ht > 3'd0) ? 5'(v.hours - 5'd10) : 5'(5'(hu) + 5'd20);
         DIG_HOUR_UNIT: begin
            if (ht < 3'd2)
               r.hours = (hu > 4'd0) ? 5'(v.hours - 5'd1) : 5'(5'(ht) * 5'd10 + 5'd9);
            else
               r.hours = (hu > 4'd0) ? 5'(v.hours - 5'd1) : 5'(5'(ht) * 5'd10 + 5'd3);
         end
         DIG_MIN_TENS:  r.minutes = (mt > 3'd0) ? 6'(v.minutes - 6'd10)
                                                : 6'(6'(mu) + 6'd50);
         DIG_MIN_UNIT:  r.minutes = (mu > 4'd0) ? 6'(v.minutes - 6'd1)
                                                : 6'(6'(mt) * 6'd10 + 6'd9);
         default: ;
      endcase
      return r;
   endfunction

endpackage

>>> design/ctse_event.sv
// ----------------------------------------------------------------------------
// ctse_event
// Next-state and result logic for one request against the held edit state.
// ----------------------------------------------------------------------------
module ctse_event
   import ctse_pkg::*;
(
   input  state_type    cur,
   input  req_data_type req,
   input  logic [15:0]  idle_ticks,
   output state_type    nxt,
   output rsp_data_type rsp
);

   logic [4:0]  h_start;
   logic [5:0]  m_start;
   logic [2:0]  sel_next;
   hm_type      hm_next, hm_up, hm_down;
   logic [15:0] left_dec;
   logic [2:0]  status;

   // Saturate start values
   assign h_start = (req.start_hours > HOURS_MAX) ? HOURS_MAX : req.start_hours;
   assign m_start = (req.start_minutes > MINUTES_MAX) ? MINUTES_MAX : req.start_minutes;

   // Next button: clamp 24..29 when leaving the hours tens, then advance
   always_comb begin
      hm_next.hours   = cur.hours_val;
      hm_next.minutes = cur.minutes_val;
      sel_next        = cur.digit_sel;
      if (req.btn_next) begin
         if (cur.digit_sel == DIG_HOUR_TENS && cur.hours_val >= 5'd24
             && cur.hours_val <= 5'd29)
            hm_next.hours = HOURS_MAX;
         if (cur.digit_sel < DIG_DONE)
            sel_next = 3'(cur.digit_sel + 3'd1);
      end
   end

   // Up then down on the digit selected after next
   assign hm_up   = req.btn_up ? digit_up(sel_next, hm_next) : hm_next;
   assign hm_down = req.btn_down ? digit_down(sel_next, hm_up) : hm_up;

   assign left_dec = (cur.idle_left != 16'd0) ? 16'(cur.idle_left - 16'd1) : 16'd0;

   // Event dispatch
   always_comb begin
      nxt    = cur;
      status = ST_IGNORED;
      case (req.opcode)
         OP_START: begin
            nxt.hours_val   = h_start;
            nxt.minutes_val = m_start;
            nxt.digit_sel   = DIG_HOUR_TENS;
            nxt.editing     = 1'b1;
            nxt.idle_left   = idle_ticks;
            status          = ST_EDITING;
         end
         OP_PRESS: begin
            if (cur.editing) begin
               nxt.idle_left = idle_ticks;
               nxt.digit_sel = sel_next;
               if (req.btn_cancel) begin
                  nxt.hours_val   = hm_next.hours;
                  nxt.minutes_val = hm_next.minutes;
                  nxt.editing     = 1'b0;
                  status          = ST_CANCEL;
               end else begin
                  nxt.hours_val   = hm_down.hours;
                  nxt.minutes_val = hm_down.minutes;
                  if (sel_next > DIG_MIN_UNIT) begin
                     nxt.editing = 1'b0;
                     status      = ST_COMMIT;
                  end else begin
                     status      = ST_EDITING;
                  end
               end
            end
         end
         OP_TICK: begin
            if (cur.editing) begin
               nxt.idle_left = left_dec;
               if (left_dec == 16'd0) begin
                  nxt.editing = 1'b0;
                  status      = ST_TIMEOUT;
               end else begin
                  status      = ST_EDITING;
               end
            end
         end
         default: ;
      endcase
   end

   // Result reports the state after the event
   assign rsp.status         = status;
   assign rsp.edit_hours     = nxt.hours_val;
   assign rsp.edit_minutes   = nxt.minutes_val;
   assign rsp.selected_digit = nxt.digit_sel;

endmodule

>>> design/clock_time_set_editor_core.sv
// ----------------------------------------------------------------------------
// clock_time_set_editor_core
// Event-driven 24-hour time editor with an idle timeout register.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid / req_data and are taken at a clock edge
//   with req_valid high and req_stall low. Each request (start, press, tick
//   or an unused code) yields exactly one response on rsp_valid / rsp_data,
//   taken when rsp_valid is high and rsp_stall is low.
//   The response is registered: it is loaded into the output register at
//   the edge that takes the request. Throughput is one request per cycle
//   while req_stall is low; the whole event is worked out by the digit
//   logic between the state registers and the output register.
//   When the receiver stalls, the held response stays put and req_stall is
//   raised while the output register is full and stalled; it falls as soon
//   as the response drains, and the next request may enter in that cycle.
//   The idle_ticks register sits at byte address 0 of the csr_ port. The
//   user must write it only while the editor has no response outstanding;
//   the block does not enforce this. Synchronous reset returns to idle,
//   empties the output register and sets idle_ticks to 1000.
// ----------------------------------------------------------------------------
module clock_time_set_editor_core
   import ctse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   state_type    state_ff, state_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff;
   logic [15:0]  idle_ticks_ff;
   logic         req_take;
   logic         csr_write;

   // Handshakes
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready
                      & (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_IDLE_TICKS);

   // Register read
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_IDLE_TICKS)
                       ? {16'd0, idle_ticks_ff} : 32'd0;

   // Event logic
   ctse_event u_event (
      .cur        (state_ff),
      .req        (req_data),
      .idle_ticks (idle_ticks_ff),
      .nxt        (state_in),
      .rsp        (rsp_data_in)
   );

   // State, config and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.editing     <= 1'b0;
         state_ff.digit_sel   <= DIG_HOUR_TENS;
         state_ff.hours_val   <= 5'd0;
         state_ff.minutes_val <= 6'd0;
         state_ff.idle_left   <= 16'd0;
         idle_ticks_ff        <= IDLE_TICKS_RESET;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (csr_write)
            idle_ticks_ff <= csr_pwdata[15:0];
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (req_take)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> verif/clock_time_set_editor_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_time_set_editor_core_test
// Self-checking bench for the 24-hour time set editor. A short table walks
// idle events, saturating starts, digit wrap, clamping, commit, cancel and
// timeout. Random edit sessions follow under several idle_ticks settings.
// Both handshakes idle at random, with one long response hold-off. Every
// response is checked field by field against a local editor model or table.
// ----------------------------------------------------------------------------
module clock_time_set_editor_core_test;
   import ctse_pkg::*;

   // opcode with no meaning; the editor must report it as ignored
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int PHASE_EVENTS = 145;

   typedef struct {
      bit           is_csr;
      logic [15:0]  csr_value;
      req_data_type req;
      bit           typed;
      rsp_data_type want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_data_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_data_type          rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // local copy of the editor state and its register
   bit          ed_active;
   logic [2:0]  ed_digit;
   logic [4:0]  ed_hours;
   logic [5:0]  ed_minutes;
   logic [15:0] ed_idle_left;
   logic [15:0] ed_idle_ticks;

   rsp_data_type pending_results[$];
   plan_row_type plan[$];
   int           mismatches = 0;
   int           quiet_cycles = 0;
   int           send_calm = 0;
   int           recv_calm = 0;
   int           recv_hold = 0;
   bit           squeeze_request = 1'b0;

   clock_time_set_editor_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void flag_error(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endfunction

   // ---------------------------------------------------------------------
   // Editor model
   // ---------------------------------------------------------------------
   function automatic void editor_reset();
      ed_idle_ticks = IDLE_TICKS_RESET;
      ed_active     = 1'b0;
      ed_digit      = DIG_HOUR_TENS;
      ed_hours      = '0;
      ed_minutes    = '0;
      ed_idle_left  = '0;
   endfunction

   // up or down on the selected digit, wrapping within its limits
   function automatic void step_digit(input bit up);
      int h, m, ht, hu, mt, mu, lim;
      h  = ed_hours;
      m  = ed_minutes;
      ht = h / 10;
      hu = h % 10;
      mt = m / 10;
      mu = m % 10;
      case (ed_digit)
         DIG_HOUR_TENS: h = up ? ((ht < 2) ? h + 10 : hu) : ((ht > 0) ? h - 10 : hu + 20);
         DIG_HOUR_UNIT: begin
            // units run to 9 below twenty, to 3 from twenty on
            lim = (ht < 2) ? 9 : 3;
            h = up ? ((hu < lim) ? h + 1 : ht * 10) : ((hu > 0) ? h - 1 : ht * 10 + lim);
         end
         DIG_MIN_TENS:  m = up ? ((mt < 5) ? m + 10 : mu) : ((mt > 0) ? m - 10 : mu + 50);
         DIG_MIN_UNIT:  m = up ? ((mu < 9) ? m + 1 : mt * 10) : ((mu > 0) ? m - 1 : mt * 10 + 9);
         default: ;
      endcase
      ed_hours   = 5'(h);
      ed_minutes = 6'(m);
   endfunction

   // advance the model by one event and return the response it gives
   function automatic rsp_data_type next_editor_result(input req_data_type d);
      rsp_data_type r;
      logic [2:0]   st;
      st = ST_IGNORED;
      if (d.opcode == OP_START) begin
         ed_hours     = (d.start_hours > HOURS_MAX) ? HOURS_MAX : d.start_hours;
         ed_minutes   = (d.start_minutes > MINUTES_MAX) ? MINUTES_MAX : d.start_minutes;
         ed_digit     = DIG_HOUR_TENS;
         ed_active    = 1'b1;
         ed_idle_left = ed_idle_ticks;
         st           = ST_EDITING;
      end else if (d.opcode == OP_PRESS && ed_active) begin
         ed_idle_left = ed_idle_ticks;
         st           = ST_EDITING;
         if (d.btn_next) begin
            // leaving the hour tens pulls 24..29 back to 23
            if (ed_digit == DIG_HOUR_TENS && ed_hours > HOURS_MAX) ed_hours = HOURS_MAX;
            if (ed_digit < DIG_DONE) ed_digit = ed_digit + 3'd1;
         end
         if (d.btn_cancel) begin
            st        = ST_CANCEL;
            ed_active = 1'b0;
         end else begin
            if (d.btn_up) step_digit(1'b1);
            if (d.btn_down) step_digit(1'b0);
            if (ed_digit == DIG_DONE) begin
               st        = ST_COMMIT;
               ed_active = 1'b0;
            end
         end
      end else if (d.opcode == OP_TICK && ed_active) begin
         if (ed_idle_left != 16'd0) ed_idle_left = ed_idle_left - 16'd1;
         if (ed_idle_left == 16'd0) begin
            st        = ST_TIMEOUT;
            ed_active = 1'b0;
         end else begin
            st = ST_EDITING;
         end
      end
      r.status         = st;
      r.edit_hours     = ed_hours;
      r.edit_minutes   = ed_minutes;
      r.selected_digit = ed_digit;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------------
   function automatic req_data_type start_req(input int h, input int m);
      req_data_type d;
      d = '0;
      d.opcode        = OP_START;
      d.start_hours   = 5'(h);
      d.start_minutes = 6'(m);
      return d;
   endfunction

   function automatic req_data_type press_req(input bit n, input bit c, input bit u, input bit dn);
      req_data_type d;
      d = '0;
      d.opcode     = OP_PRESS;
      d.btn_next   = n;
      d.btn_cancel = c;
      d.btn_up     = u;
      d.btn_down   = dn;
      return d;
   endfunction

   function automatic req_data_type op_req(input logic [1:0] op);
      req_data_type d;
      d = '0;
      d.opcode = op;
      return d;
   endfunction

   function automatic plan_row_type pred_row(input req_data_type d);
      plan_row_type p;
      p = '{is_csr: 1'b0, csr_value: '0, req: d, typed: 1'b0, want: '0};
      return p;
   endfunction

   function automatic plan_row_type fixed_row(input req_data_type d, input logic [2:0] st,
                                              input int h, input int m, input logic [2:0] dg);
      plan_row_type p;
      p = pred_row(d);
      p.typed = 1'b1;
      p.want  = '{status: st, edit_hours: 5'(h), edit_minutes: 6'(m), selected_digit: dg};
      return p;
   endfunction

   function automatic plan_row_type csr_row(input int v);
      plan_row_type p;
      p = pred_row('0);
      p.is_csr    = 1'b1;
      p.csr_value = 16'(v);
      return p;
   endfunction

   // random event, mostly well-formed edit sessions with some noise
   function automatic req_data_type random_request();
      req_data_type                   d;
      logic [$bits(req_data_type)-1:0] raw;
      int                             roll, pick;
      raw  = $bits(req_data_type)'($urandom);
      d    = raw;
      roll = $urandom_range(0, 99);
      if (!ed_active)
         d.opcode = (roll < 75) ? OP_START : (roll < 85) ? OP_PRESS :
                    (roll < 95) ? OP_TICK : OP_UNUSED;
      else
         d.opcode = (roll < 3) ? OP_START : (roll < 6) ? OP_UNUSED :
                    (roll < 22) ? OP_TICK : OP_PRESS;
      // mostly legal start times, now and then out of range
      if (d.opcode == OP_START && $urandom_range(0, 9) != 0) begin
         d.start_hours   = 5'($urandom_range(0, 23));
         d.start_minutes = 6'($urandom_range(0, 59));
      end
      if (d.opcode == OP_PRESS) begin
         pick = $urandom_range(0, 99);
         if (pick < 95) begin
            {d.btn_next, d.btn_cancel, d.btn_up, d.btn_down} =
               (pick < 25) ? 4'b1000 : (pick < 50) ? 4'b0010 :
               (pick < 75) ? 4'b0001 : (pick < 80) ? 4'b0000 :
               {d.btn_next, 1'b0, d.btn_up, d.btn_down};
         end
      end
      return d;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   task automatic sender_pause();
      int gap, roll;
      roll = $urandom_range(0, 99);
      gap  = 0;
      if (send_calm > 0) send_calm--;
      else if (roll < 2) send_calm = $urandom_range(20, 80);
      else if (roll < 55) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // offer one request, record what it must give once taken
   task automatic send_request(input req_data_type d, input bit typed,
                               input rsp_data_type want, output bit counted);
      rsp_data_type r;
      sender_pause();
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
      r = next_editor_result(d);
      counted = (r.status != ST_IGNORED);
      pending_results.push_back(typed ? want : r);
      @(negedge clock);
   endtask

   // let every outstanding response come home before touching the register
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // write idle_ticks, then read it back
   task automatic write_idle_ticks(input logic [15:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * CSR_IDX_IDLE_TICKS);
      csr_pwdata  <= {16'd0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ed_idle_ticks = v;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== v)
         flag_error($sformatf("idle_ticks read back: expected %0d, got %0d", v, csr_prdata[15:0]));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int          useful;
      bit          counted;
      logic [15:0] setting;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      editor_reset();

      // idle events and the unused code hold the reset values
      plan.push_back(fixed_row(press_req(1, 1, 1, 1), ST_IGNORED, 0, 0, DIG_HOUR_TENS));
      plan.push_back(fixed_row(op_req(OP_TICK), ST_IGNORED, 0, 0, DIG_HOUR_TENS));
      plan.push_back(fixed_row(op_req(OP_UNUSED), ST_IGNORED, 0, 0, DIG_HOUR_TENS));
      // start saturates, and a second start restarts the edit
      plan.push_back(fixed_row(start_req(31, 63), ST_EDITING, 23, 59, DIG_HOUR_TENS));
      plan.push_back(fixed_row(start_req(0, 0), ST_EDITING, 0, 0, DIG_HOUR_TENS));
      plan.push_back(pred_row(press_req(0, 0, 0, 1)));
      // hours up to 24, clamped on leaving the tens
      plan.push_back(fixed_row(start_req(14, 0), ST_EDITING, 14, 0, DIG_HOUR_TENS));
      plan.push_back(pred_row(press_req(0, 0, 1, 0)));
      plan.push_back(pred_row(press_req(1, 0, 0, 0)));
      plan.push_back(pred_row(press_req(0, 0, 1, 0)));
      plan.push_back(pred_row(press_req(0, 0, 0, 1)));
      // minute digits wrap both ways, then commit
      plan.push_back(pred_row(press_req(1, 0, 0, 1)));
      plan.push_back(pred_row(press_req(0, 0, 1, 0)));
      plan.push_back(pred_row(press_req(1, 0, 0, 1)));
      plan.push_back(pred_row(press_req(0, 0, 1, 0)));
      plan.push_back(fixed_row(press_req(1, 0, 0, 0), ST_COMMIT, 23, 0, DIG_DONE));
      plan.push_back(fixed_row(press_req(0, 0, 1, 0), ST_IGNORED, 23, 0, DIG_DONE));
      // all buttons at once: next moves, cancel wins
      plan.push_back(fixed_row(start_req(12, 30), ST_EDITING, 12, 30, DIG_HOUR_TENS));
      plan.push_back(fixed_row(press_req(1, 1, 1, 1), ST_CANCEL, 12, 30, DIG_HOUR_UNIT));
      // up and down past the last digit do nothing
      plan.push_back(pred_row(start_req(9, 59)));
      plan.push_back(pred_row(press_req(1, 0, 0, 0)));
      plan.push_back(pred_row(press_req(1, 0, 0, 0)));
      plan.push_back(pred_row(press_req(1, 0, 0, 0)));
      plan.push_back(fixed_row(press_req(1, 0, 1, 1), ST_COMMIT, 9, 59, DIG_DONE));
      // shortest timeouts, including a timer that starts at zero
      plan.push_back(csr_row(1));
      plan.push_back(pred_row(start_req(5, 5)));
      plan.push_back(fixed_row(op_req(OP_TICK), ST_TIMEOUT, 5, 5, DIG_HOUR_TENS));
      plan.push_back(csr_row(0));
      plan.push_back(pred_row(start_req(0, 59)));
      plan.push_back(fixed_row(op_req(OP_TICK), ST_TIMEOUT, 0, 59, DIG_HOUR_TENS));
      plan.push_back(csr_row(65535));
      plan.push_back(pred_row(start_req(23, 0)));
      plan.push_back(fixed_row(op_req(OP_TICK), ST_EDITING, 23, 0, DIG_HOUR_TENS));

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            settle();
            write_idle_ticks(plan[i].csr_value);
         end else begin
            send_request(plan[i].req, plan[i].typed, plan[i].want, counted);
         end
      end

      // random sessions under a spread of timeout settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: setting = 16'd3;
            1: setting = IDLE_TICKS_RESET;
            2: setting = 16'($urandom_range(4, 20));
            3: setting = 16'd1;
            4: setting = 16'($urandom);
            default: setting = 16'd2;
         endcase
         settle();
         write_idle_ticks(setting);
         if (phase == 0) squeeze_request = 1'b1;
         useful = 0;
         while (useful < PHASE_EVENTS) begin
            send_request(random_request(), 1'b0, '0, counted);
            if (counted) useful++;
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: random stalls, calm stretches and one long hold-off
   // ---------------------------------------------------------------------
   initial begin : responder
      int roll;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         roll = $urandom_range(0, 99);
         if (squeeze_request) begin
            squeeze_request = 1'b0;
            recv_hold = SQUEEZE_CYCLES;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_stall <= 1'b1;
         end else if (recv_calm > 0) begin
            recv_calm--;
            rsp_stall <= 1'b0;
         end else if (roll < 3) begin
            recv_calm = $urandom_range(20, 100);
            rsp_stall <= 1'b0;
         end else if (roll < 5) begin
            recv_hold = $urandom_range(10, 40);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (roll < 35);
         end
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin : response_check
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            flag_error("response with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status)
               flag_error($sformatf("status: expected %0d, got %0d",
                                    want.status, rsp_data.status));
            if (rsp_data.edit_hours !== want.edit_hours)
               flag_error($sformatf("edit_hours: expected %0d, got %0d",
                                    want.edit_hours, rsp_data.edit_hours));
            if (rsp_data.edit_minutes !== want.edit_minutes)
               flag_error($sformatf("edit_minutes: expected %0d, got %0d",
                                    want.edit_minutes, rsp_data.edit_minutes));
            if (rsp_data.selected_digit !== want.selected_digit)
               flag_error($sformatf("selected_digit: expected %0d, got %0d",
                                    want.selected_digit, rsp_data.selected_digit));
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

>>> files.f
design/ctse_pkg.sv
design/ctse_event.sv
design/clock_time_set_editor_core.sv
verif/clock_time_set_editor_core_test.sv
